### rtl/i2cbe_pkg.sv
// i2cbe_pkg: shared types, codes and the per-tick step function of the i2c bit engine
// no dependencies; used by i2cbe_core and i2c_master_bit_engine_top
package i2cbe_pkg;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int STEP_PASSES = 6;

  localparam logic [CFG_W-1:0] HALF_RST = 16'd50;
  localparam logic [CFG_W-1:0] TMO_RST  = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_HALF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TMO  = 1'b1;

  // commands
  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_STOP    = 3'd2;
  localparam logic [2:0] ACT_WRITE   = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;
  localparam logic [2:0] ACT_RECOVER = 3'd5;

  // completion status
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_BUSY    = 3'd2;
  localparam logic [2:0] ST_STUCK   = 3'd3;
  localparam logic [2:0] ST_REFUSED = 3'd4;

  // sequencer phases
  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_HALF  = 5'd1;
  localparam logic [4:0] PH_RAISE = 5'd2;
  localparam logic [4:0] PH_S1    = 5'd3;
  localparam logic [4:0] PH_S2    = 5'd4;
  localparam logic [4:0] PH_W0    = 5'd5;
  localparam logic [4:0] PH_W1    = 5'd6;
  localparam logic [4:0] PH_W2    = 5'd7;
  localparam logic [4:0] PH_W3    = 5'd8;
  localparam logic [4:0] PH_W4    = 5'd9;
  localparam logic [4:0] PH_W5    = 5'd10;
  localparam logic [4:0] PH_R0    = 5'd11;
  localparam logic [4:0] PH_R1    = 5'd12;
  localparam logic [4:0] PH_R2    = 5'd13;
  localparam logic [4:0] PH_R3    = 5'd14;
  localparam logic [4:0] PH_R4    = 5'd15;
  localparam logic [4:0] PH_P0    = 5'd16;
  localparam logic [4:0] PH_P1    = 5'd17;
  localparam logic [4:0] PH_P2    = 5'd18;
  localparam logic [4:0] PH_P3    = 5'd19;
  localparam logic [4:0] PH_V0    = 5'd20;
  localparam logic [4:0] PH_V1    = 5'd21;
  localparam logic [4:0] PH_FIN   = 5'd22;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] MAX_PULSES    = 4'd9;

  typedef struct packed {
    logic [4:0]       phase;
    logic [4:0]       ret_phase;
    logic [3:0]       bit_count;
    logic [7:0]       shift_byte;
    logic [CFG_W-1:0] wait_count;
    logic [CFG_W-1:0] stretch_count;
    logic [3:0]       pulse_count;
    logic             drv_scl;
    logic             drv_sda;
    logic [2:0]       pending_fail;
    logic [2:0]       cmd;
    logic             ack_choice;
    logic             ack_bit;
  } eng_st_t;

  localparam eng_st_t ENG_RST = '{
    phase:         PH_IDLE,
    ret_phase:     PH_IDLE,
    bit_count:     4'd0,
    shift_byte:    8'd0,
    wait_count:    16'd0,
    stretch_count: 16'd0,
    pulse_count:   4'd0,
    drv_scl:       1'b1,
    drv_sda:       1'b1,
    pending_fail:  ST_OK,
    cmd:           ACT_NONE,
    ack_choice:    1'b0,
    ack_bit:       1'b0
  };

  typedef struct packed {
    eng_st_t    st;
    logic       again;
    logic       done;
    logic [2:0] status;
  } work_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] read_data;
    logic       ack_received;
  } res_t;

  function automatic work_t go_half(work_t w, logic [4:0] nxt, logic [CFG_W-1:0] half);
    work_t r;
    r = w;
    r.st.wait_count = half;
    r.st.ret_phase  = nxt;
    r.st.phase      = PH_HALF;
    return r;
  endfunction

  function automatic work_t go_raise(work_t w, logic [4:0] nxt);
    work_t r;
    r = w;
    r.st.drv_scl       = 1'b1;
    r.st.stretch_count = '0;
    r.st.ret_phase     = nxt;
    r.st.phase         = PH_RAISE;
    return r;
  endfunction

  function automatic work_t finish(work_t w, logic [2:0] st);
    work_t r;
    r = w;
    r.done     = 1'b1;
    r.status   = st;
    r.st.phase = PH_IDLE;
    return r;
  endfunction

  // one pass of the sequencer; a no-op unless again is set
  function automatic work_t tick_step(work_t w, logic scl, logic sda,
                                      logic [CFG_W-1:0] half, logic [CFG_W-1:0] lim);
    work_t            r;
    logic [CFG_W-1:0] cnt;
    logic [3:0]       bc;
    r   = w;
    cnt = w.st.stretch_count + 16'd1;
    bc  = w.st.bit_count + 4'd1;
    if (w.again) begin
      r.again = 1'b0;
      unique case (w.st.phase)
        PH_HALF: begin
          if (w.st.wait_count > 16'd1) begin
            r.st.wait_count = w.st.wait_count - 16'd1;
          end else begin
            r.st.phase = w.st.ret_phase;
            r.again    = 1'b1;
          end
        end
        PH_RAISE: begin
          if (scl) begin
            r = go_half(r, w.st.ret_phase, half);
          end else begin
            r.st.stretch_count = cnt;
            if (cnt >= lim) begin
              if (w.st.ret_phase == PH_P2 || w.st.ret_phase == PH_R4) begin
                r.st.pending_fail = ST_TIMEOUT;
                r.st.phase        = w.st.ret_phase;
                r.again           = 1'b1;
              end else begin
                r = finish(r, ST_TIMEOUT);
              end
            end
          end
        end
        PH_S1: begin
          if (!sda) begin
            r = finish(r, ST_BUSY);
          end else begin
            r.st.drv_sda = 1'b0;
            r = go_half(r, PH_S2, half);
          end
        end
        PH_S2: begin
          r.st.drv_scl = 1'b0;
          r = go_half(r, PH_FIN, half);
        end
        PH_W0: begin
          r.st.drv_sda = w.st.shift_byte[7];
          r = go_half(r, PH_W1, half);
        end
        PH_W1: r = go_raise(r, PH_W2);
        PH_W2: begin
          r.st.drv_scl    = 1'b0;
          r.st.shift_byte = {w.st.shift_byte[6:0], 1'b0};
          r.st.bit_count  = bc;
          r = go_half(r, (bc >= BITS_PER_BYTE) ? PH_W3 : PH_W0, half);
        end
        PH_W3: begin
          r.st.drv_sda = 1'b1;
          r = go_half(r, PH_W4, half);
        end
        PH_W4: r = go_raise(r, PH_W5);
        PH_W5: begin
          r.st.ack_bit = !sda;
          r.st.drv_scl = 1'b0;
          r = go_half(r, PH_FIN, half);
        end
        PH_R0: r = go_raise(r, PH_R1);
        PH_R1: begin
          r.st.shift_byte = {w.st.shift_byte[6:0], sda};
          r.st.drv_scl    = 1'b0;
          r.st.bit_count  = bc;
          r = go_half(r, (bc >= BITS_PER_BYTE) ? PH_R2 : PH_R0, half);
        end
        PH_R2: begin
          r.st.drv_sda = !w.st.ack_choice;
          r = go_half(r, PH_R3, half);
        end
        PH_R3: r = go_raise(r, PH_R4);
        PH_R4: begin
          r.st.drv_scl = 1'b0;
          r.st.drv_sda = 1'b1;
          r = go_half(r, PH_FIN, half);
        end
        PH_P0: begin
          r.st.drv_scl = 1'b0;
          r.st.drv_sda = 1'b0;
          r = go_half(r, PH_P1, half);
        end
        PH_P1: r = go_raise(r, PH_P2);
        PH_P2: begin
          r.st.drv_sda = 1'b1;
          r = go_half(r, PH_P3, half);
        end
        PH_P3: begin
          if (w.st.pending_fail != ST_OK) begin
            r = finish(r, w.st.pending_fail);
          end else if (!scl || !sda) begin
            r = finish(r, ST_STUCK);
          end else begin
            r = finish(r, ST_OK);
          end
        end
        PH_V0: begin
          if (sda || w.st.pulse_count >= MAX_PULSES) begin
            r.st.phase = PH_P0;
            r.again    = 1'b1;
          end else begin
            r.st.drv_scl = 1'b0;
            r = go_half(r, PH_V1, half);
          end
        end
        PH_V1: begin
          r.st.pulse_count = w.st.pulse_count + 4'd1;
          r = go_raise(r, PH_V0);
        end
        PH_FIN: r = finish(r, w.st.pending_fail);
        default: r.st.phase = PH_IDLE;
      endcase
    end
    return r;
  endfunction

endpackage

### rtl/i2cbe_core.sv
// i2cbe_core: sequencer state registers and the per-tick next-state logic
// depends on i2cbe_pkg (types, codes, tick_step)
module i2cbe_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [2:0]                 action,
  input  logic [7:0]                 write_data,
  input  logic                       ack_reply,
  input  logic                       scl_level,
  input  logic                       sda_level,
  input  logic [i2cbe_pkg::CFG_W-1:0] half_period_ticks,
  input  logic [i2cbe_pkg::CFG_W-1:0] stretch_timeout_ticks,
  output i2cbe_pkg::res_t            res
);
  import i2cbe_pkg::*;

  eng_st_t          eng_r;
  eng_st_t          eng_nxt;
  work_t            w;
  logic [CFG_W-1:0] half_ld;
  logic [CFG_W-1:0] lim;

  assign half_ld = (half_period_ticks != '0) ? half_period_ticks : 16'd1;
  assign lim     = (stretch_timeout_ticks != '0) ? stretch_timeout_ticks : 16'd1;

  always_comb begin
    w        = '0;
    w.st     = eng_r;
    if (eng_r.phase == PH_IDLE && action != ACT_NONE) begin
      w.st.cmd          = action;
      w.st.pending_fail = ST_OK;
      unique case (action)
        ACT_START: begin
          w.st.drv_sda = 1'b1;
          w = go_raise(w, PH_S1);
        end
        ACT_STOP: begin
          w.st.phase = PH_P0;
          w.again    = 1'b1;
        end
        ACT_WRITE: begin
          w.st.shift_byte = write_data;
          w.st.bit_count  = '0;
          w.st.ack_bit    = 1'b0;
          w.st.phase      = PH_W0;
          w.again         = 1'b1;
        end
        ACT_READ: begin
          w.st.ack_choice = ack_reply;
          w.st.drv_sda    = 1'b1;
          w.st.shift_byte = '0;
          w.st.bit_count  = '0;
          w.st.phase      = PH_R0;
          w.again         = 1'b1;
        end
        ACT_RECOVER: begin
          w.st.drv_scl     = 1'b1;
          w.st.drv_sda     = 1'b1;
          w.st.pulse_count = '0;
          w.st.phase       = PH_V0;
        end
        default: w = finish(w, ST_REFUSED);
      endcase
    end else if (eng_r.phase != PH_IDLE) begin
      w.again = 1'b1;
    end
    for (int i = 0; i < STEP_PASSES; i++) begin
      w = tick_step(w, scl_level, sda_level, half_ld, lim);
    end
  end

  assign eng_nxt = w.st;

  always_comb begin
    res.scl_release  = w.st.drv_scl;
    res.sda_release  = w.st.drv_sda;
    res.busy_res     = (w.st.phase != PH_IDLE);
    res.done_res     = w.done;
    res.status       = w.done ? w.status : ST_OK;
    res.read_data    = (w.done && w.st.cmd == ACT_READ && w.status == ST_OK) ?
                       w.st.shift_byte : 8'd0;
    res.ack_received = w.done && w.st.cmd == ACT_WRITE && w.status == ST_OK &&
                       w.st.ack_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_r <= ENG_RST;
    end else if (accept) begin
      eng_r <= eng_nxt;
    end
  end

endmodule

### rtl/i2c_master_bit_engine_top.sv
// i2c master bit engine: one result beat per input tick, registered on accept
// one tick per cycle unless in_stall; each whole tick is combinational in i2cbe_core
// a two-entry output buffer keeps in_stall low unless both entries hold unread beats
// rst_n is synchronous, active low: sequencer idle with both lines released,
// half period 50 and stretch timeout 100 ticks, output buffer empty
// depends on i2cbe_pkg and i2cbe_core
module i2c_master_bit_engine_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_action,
  input  logic [7:0]                     in_write_data,
  input  logic                           in_ack_reply,
  input  logic                           in_scl_level,
  input  logic                           in_sda_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_scl_release,
  output logic                           out_sda_release,
  output logic                           out_busy_res,
  output logic                           out_done_res,
  output logic [2:0]                     out_status,
  output logic [7:0]                     out_read_data,
  output logic                           out_ack_received,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [i2cbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cbe_pkg::CFG_W-1:0]     cfg_data
);
  import i2cbe_pkg::*;

  logic [CFG_W-1:0] half_r;
  logic [CFG_W-1:0] tmo_r;
  logic             in_acc;
  logic             out_fire;
  res_t             res;
  res_t             out_r;
  res_t             skid_r;
  logic             ov_r;
  logic             sv_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = sv_r;
  assign in_acc    = in_valid && !sv_r;
  assign out_fire  = ov_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_RST;
      tmo_r  <= TMO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF: half_r <= cfg_data;
        REG_TMO:  tmo_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cbe_core u_core (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .accept                (in_acc),
    .action                (in_action),
    .write_data            (in_write_data),
    .ack_reply             (in_ack_reply),
    .scl_level             (in_scl_level),
    .sda_level             (in_sda_level),
    .half_period_ticks     (half_r),
    .stretch_timeout_ticks (tmo_r),
    .res                   (res)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (!ov_r || out_fire) begin
      if (sv_r) begin
        out_r <= skid_r;
        ov_r  <= 1'b1;
        sv_r  <= 1'b0;
      end else if (in_acc) begin
        out_r <= res;
        ov_r  <= 1'b1;
      end else begin
        ov_r <= 1'b0;
      end
    end else if (in_acc) begin
      skid_r <= res;
      sv_r   <= 1'b1;
    end
  end

  assign out_valid        = ov_r;
  assign out_scl_release  = out_r.scl_release;
  assign out_sda_release  = out_r.sda_release;
  assign out_busy_res     = out_r.busy_res;
  assign out_done_res     = out_r.done_res;
  assign out_status       = out_r.status;
  assign out_read_data    = out_r.read_data;
  assign out_ack_received = out_r.ack_received;

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r) else $error("skid entry holds a beat while output is empty");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall) else $error("output buffer not empty after reset");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("finished beat still reports busy");

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == ST_OK && out_read_data == 8'd0 &&
    !out_ack_received) else $error("completion fields set without done");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r && !out_stall |=> !sv_r && ov_r) else $error("skid entry did not move forward");
`endif

endmodule

### verif/i2c_master_bit_engine_top_tb.sv
`timescale 1ns / 1ps
// i2c_master_bit_engine_top_tb: checks every result beat of the i2c bit engine against a local
// tick-level sequencer model; directed commands, random bus traffic, output hold, config extremes
// depends on i2cbe_pkg and i2c_master_bit_engine_top
module i2c_master_bit_engine_top_tb;
  import i2cbe_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int PRINT_CAP     = 40;

  localparam logic [2:0] ACT_BAD_6 = 3'd6;
  localparam logic [2:0] ACT_BAD_7 = 3'd7;

  typedef enum {
    BUS_IDLE_HIGH, BUS_DATA_LOW, BUS_STUCK_LOW, BUS_ACK_STRETCH, BUS_SCL_DROP, BUS_NOISY
  } bus_mode_t;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_action     = ACT_NONE;
  logic [7:0]           in_write_data = 8'h00;
  logic                 in_ack_reply  = 1'b0;
  logic                 in_scl_level  = 1'b1;
  logic                 in_sda_level  = 1'b1;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic                 out_scl_release;
  logic                 out_sda_release;
  logic                 out_busy_res;
  logic                 out_done_res;
  logic [2:0]           out_status;
  logic [7:0]           out_read_data;
  logic                 out_ack_received;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = REG_HALF;
  logic [CFG_W-1:0]     cfg_data      = '0;

  int cycles         = 0;
  int errors         = 0;
  int ticks_sent     = 0;
  int cmds_done      = 0;
  int cfg_writes     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_taken     = 0;
  int hold_left      = 0;

  res_t ticks_due[$];
  res_t want;

  // sequencer model state
  logic [CFG_W-1:0] half_cfg  = HALF_RST;
  logic [CFG_W-1:0] tmo_cfg   = TMO_RST;
  logic [4:0]       ph        = PH_IDLE;
  logic [4:0]       resume    = PH_IDLE;
  logic [3:0]       bits      = '0;
  logic [3:0]       pulses    = '0;
  logic [7:0]       sreg      = '0;
  logic [CFG_W-1:0] wait_left = '0;
  logic [CFG_W-1:0] stretch   = '0;
  logic             scl_rel   = 1'b1;
  logic             sda_rel   = 1'b1;
  logic [2:0]       fail_code = ST_OK;
  logic [2:0]       op        = ACT_NONE;
  logic             ack_want  = 1'b0;
  logic             ack_seen  = 1'b0;
  logic             done_now;
  logic [2:0]       done_code;

  i2c_master_bit_engine_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_write_data    (in_write_data),
    .in_ack_reply     (in_ack_reply),
    .in_scl_level     (in_scl_level),
    .in_sda_level     (in_sda_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl_release  (out_scl_release),
    .out_sda_release  (out_sda_release),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_status       (out_status),
    .out_read_data    (out_read_data),
    .out_ack_received (out_ack_received),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycles, ticks_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("cycle %0d: %s got %0h, want %0h", cycles, what, got, exp_val);
    end
  endtask

  task automatic enter_wait(input logic [4:0] nxt);
    wait_left = (half_cfg != '0) ? half_cfg : 16'd1;
    resume    = nxt;
    ph        = PH_HALF;
  endtask

  task automatic enter_raise(input logic [4:0] nxt);
    scl_rel = 1'b1;
    stretch = '0;
    resume  = nxt;
    ph      = PH_RAISE;
  endtask

  task automatic complete(input logic [2:0] code);
    done_now  = 1'b1;
    done_code = code;
    ph        = PH_IDLE;
  endtask

  // one tick of the sequencer, up to six chained phase steps
  task automatic predict_tick(input logic [2:0] act, input logic [7:0] wd, input logic sack,
                              input logic scl, input logic sda, output res_t r);
    logic             more;
    logic [CFG_W-1:0] lim;
    int               n;
    more      = 1'b0;
    done_now  = 1'b0;
    done_code = ST_OK;
    lim       = (tmo_cfg != '0) ? tmo_cfg : 16'd1;
    if (ph == PH_IDLE && act != ACT_NONE) begin
      op        = act;
      fail_code = ST_OK;
      case (act)
        ACT_START: begin
          sda_rel = 1'b1;
          enter_raise(PH_S1);
        end
        ACT_STOP: begin
          ph   = PH_P0;
          more = 1'b1;
        end
        ACT_WRITE: begin
          sreg     = wd;
          bits     = '0;
          ack_seen = 1'b0;
          ph       = PH_W0;
          more     = 1'b1;
        end
        ACT_READ: begin
          ack_want = sack;
          sda_rel  = 1'b1;
          sreg     = '0;
          bits     = '0;
          ph       = PH_R0;
          more     = 1'b1;
        end
        ACT_RECOVER: begin
          scl_rel = 1'b1;
          sda_rel = 1'b1;
          pulses  = '0;
          ph      = PH_V0;
        end
        default: complete(ST_REFUSED);
      endcase
    end else if (ph != PH_IDLE) begin
      more = 1'b1;
    end
    for (n = 0; n < STEP_PASSES && more; n++) begin
      more = 1'b0;
      case (ph)
        PH_HALF: begin
          if (wait_left > 16'd1) begin
            wait_left = wait_left - 16'd1;
          end else begin
            ph   = resume;
            more = 1'b1;
          end
        end
        PH_RAISE: begin
          if (scl) begin
            enter_wait(resume);
          end else begin
            stretch = stretch + 16'd1;
            if (stretch >= lim) begin
              if (resume == PH_P2 || resume == PH_R4) begin
                fail_code = ST_TIMEOUT;
                ph        = resume;
                more      = 1'b1;
              end else begin
                complete(ST_TIMEOUT);
              end
            end
          end
        end
        PH_S1: begin
          if (!sda) begin
            complete(ST_BUSY);
          end else begin
            sda_rel = 1'b0;
            enter_wait(PH_S2);
          end
        end
        PH_S2: begin
          scl_rel = 1'b0;
          enter_wait(PH_FIN);
        end
        PH_W0: begin
          sda_rel = sreg[7];
          enter_wait(PH_W1);
        end
        PH_W1: enter_raise(PH_W2);
        PH_W2: begin
          scl_rel = 1'b0;
          sreg    = {sreg[6:0], 1'b0};
          bits    = bits + 4'd1;
          enter_wait((bits >= BITS_PER_BYTE) ? PH_W3 : PH_W0);
        end
        PH_W3: begin
          sda_rel = 1'b1;
          enter_wait(PH_W4);
        end
        PH_W4: enter_raise(PH_W5);
        PH_W5: begin
          ack_seen = !sda;
          scl_rel  = 1'b0;
          enter_wait(PH_FIN);
        end
        PH_R0: enter_raise(PH_R1);
        PH_R1: begin
          sreg    = {sreg[6:0], sda};
          scl_rel = 1'b0;
          bits    = bits + 4'd1;
          enter_wait((bits >= BITS_PER_BYTE) ? PH_R2 : PH_R0);
        end
        PH_R2: begin
          sda_rel = !ack_want;
          enter_wait(PH_R3);
        end
        PH_R3: enter_raise(PH_R4);
        PH_R4: begin
          scl_rel = 1'b0;
          sda_rel = 1'b1;
          enter_wait(PH_FIN);
        end
        PH_P0: begin
          scl_rel = 1'b0;
          sda_rel = 1'b0;
          enter_wait(PH_P1);
        end
        PH_P1: enter_raise(PH_P2);
        PH_P2: begin
          sda_rel = 1'b1;
          enter_wait(PH_P3);
        end
        PH_P3: begin
          if (fail_code != ST_OK) begin
            complete(fail_code);
          end else if (!scl || !sda) begin
            complete(ST_STUCK);
          end else begin
            complete(ST_OK);
          end
        end
        PH_V0: begin
          if (sda || pulses >= MAX_PULSES) begin
            ph   = PH_P0;
            more = 1'b1;
          end else begin
            scl_rel = 1'b0;
            enter_wait(PH_V1);
          end
        end
        PH_V1: begin
          pulses = pulses + 4'd1;
          enter_raise(PH_V0);
        end
        PH_FIN: complete(fail_code);
        default: ph = PH_IDLE;
      endcase
    end
    r.scl_release  = scl_rel;
    r.sda_release  = sda_rel;
    r.busy_res     = (ph != PH_IDLE);
    r.done_res     = done_now;
    r.status       = done_now ? done_code : ST_OK;
    r.read_data    = (done_now && op == ACT_READ && done_code == ST_OK) ? sreg : 8'h00;
    r.ack_received = done_now && op == ACT_WRITE && done_code == ST_OK && ack_seen;
  endtask

  task automatic send_tick(input logic [2:0] act, input logic [7:0] wd, input logic sack,
                           input logic scl, input logic sda);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_write_data <= wd;
    in_ack_reply  <= sack;
    in_scl_level  <= scl;
    in_sda_level  <= sda;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_tick(act, wd, sack, scl, sda, r);
    ticks_due.push_back(r);
    ticks_sent++;
  endtask

  // line levels a target or a faulty bus would present in the current model phase
  task automatic pick_lines(input bus_mode_t m, output logic scl, output logic sda);
    case (m)
      BUS_IDLE_HIGH: begin
        scl = 1'b1;
        sda = 1'b1;
      end
      BUS_DATA_LOW: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      BUS_STUCK_LOW: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      BUS_ACK_STRETCH: begin
        scl = !(ph == PH_RAISE && (resume == PH_R4 || resume == PH_P2));
        sda = 1'($urandom);
      end
      BUS_SCL_DROP: begin
        scl = !(ph == PH_HALF && resume == PH_P3);
        sda = 1'($urandom);
      end
      default: begin
        scl = ($urandom_range(3) != 0);
        sda = 1'($urandom);
      end
    endcase
  endtask

  // issue one command and keep ticking until the sequencer is idle again
  task automatic run_cmd(input logic [2:0] act, input logic [7:0] wd, input logic sack,
                         input bus_mode_t m);
    logic       scl;
    logic       sda;
    logic [2:0] busy_act;
    pick_lines(m, scl, sda);
    send_tick(act, wd, sack, scl, sda);
    while (ph != PH_IDLE) begin
      pick_lines(m, scl, sda);
      busy_act = ($urandom_range(3) == 0) ? 3'($urandom) : ACT_NONE;
      send_tick(busy_act, 8'($urandom), 1'($urandom), scl, sda);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ticks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_HALF) begin
      half_cfg = val;
    end else begin
      tmo_cfg = val;
    end
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] tmo);
    settle();
    write_reg(REG_HALF, half);
    write_reg(REG_TMO, tmo);
  endtask

  task automatic set_idle(input int sender_pct, input int receiver_pct);
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  task automatic random_commands(input int n);
    int         stop_at;
    int         pick;
    logic [2:0] act;
    bus_mode_t  m;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        act = ACT_NONE;
      end else if (pick < 14) begin
        act = pick[0] ? ACT_BAD_7 : ACT_BAD_6;
      end else begin
        case ($urandom_range(4))
          0: act = ACT_START;
          1: act = ACT_STOP;
          2: act = ACT_WRITE;
          3: act = ACT_READ;
          default: act = ACT_RECOVER;
        endcase
      end
      case ($urandom_range(9))
        5: m = BUS_IDLE_HIGH;
        6: m = BUS_DATA_LOW;
        7: m = BUS_STUCK_LOW;
        8: m = BUS_ACK_STRETCH;
        9: m = BUS_SCL_DROP;
        default: m = BUS_NOISY;
      endcase
      run_cmd(act, 8'($urandom), 1'($urandom), m);
    end
  endtask

  task automatic test_reset_values();
    set_idle(0, 0);
    run_cmd(ACT_START, 8'h00, 1'b0, BUS_DATA_LOW);
    run_cmd(ACT_START, 8'h00, 1'b0, BUS_STUCK_LOW);
  endtask

  task automatic test_directed_commands();
    set_idle(0, 0);
    set_config(16'd1, 16'd3);
    run_cmd(ACT_BAD_6, 8'h00, 1'b0, BUS_IDLE_HIGH);
    run_cmd(ACT_BAD_7, 8'hFF, 1'b1, BUS_IDLE_HIGH);
    run_cmd(ACT_START, 8'h00, 1'b0, BUS_IDLE_HIGH);
    run_cmd(ACT_START, 8'h00, 1'b0, BUS_DATA_LOW);
    run_cmd(ACT_START, 8'h00, 1'b0, BUS_STUCK_LOW);
    run_cmd(ACT_WRITE, 8'hFF, 1'b0, BUS_DATA_LOW);
    run_cmd(ACT_WRITE, 8'h00, 1'b1, BUS_IDLE_HIGH);
    run_cmd(ACT_WRITE, 8'hA5, 1'b0, BUS_STUCK_LOW);
    run_cmd(ACT_WRITE, 8'h5A, 1'b1, BUS_NOISY);
    run_cmd(ACT_READ, 8'h00, 1'b1, BUS_IDLE_HIGH);
    run_cmd(ACT_READ, 8'hFF, 1'b0, BUS_DATA_LOW);
    run_cmd(ACT_READ, 8'h00, 1'b1, BUS_ACK_STRETCH);
    run_cmd(ACT_READ, 8'h00, 1'b0, BUS_NOISY);
    run_cmd(ACT_STOP, 8'h00, 1'b0, BUS_IDLE_HIGH);
    run_cmd(ACT_STOP, 8'h00, 1'b0, BUS_DATA_LOW);
    run_cmd(ACT_STOP, 8'h00, 1'b0, BUS_STUCK_LOW);
    run_cmd(ACT_STOP, 8'h00, 1'b0, BUS_SCL_DROP);
    run_cmd(ACT_STOP, 8'h00, 1'b0, BUS_ACK_STRETCH);
    run_cmd(ACT_RECOVER, 8'h00, 1'b0, BUS_IDLE_HIGH);
    run_cmd(ACT_RECOVER, 8'h00, 1'b0, BUS_DATA_LOW);
    run_cmd(ACT_RECOVER, 8'h00, 1'b0, BUS_STUCK_LOW);
    run_cmd(ACT_RECOVER, 8'h00, 1'b0, BUS_NOISY);
  endtask

  task automatic test_random_traffic(input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] tmo,
                                     input int sender_pct, input int receiver_pct);
    set_config(half, tmo);
    set_idle(sender_pct, receiver_pct);
    random_commands(24);
  endtask

  // long output hold so the result buffer fills and the input stalls
  task automatic test_backpressure();
    set_config(16'd1, 16'd4);
    set_idle(0, 0);
    hold_req++;
    random_commands(24);
  endtask

  task automatic test_config_extremes();
    set_idle(0, 0);
    set_config(16'hFFFF, 16'd1);
    run_cmd(ACT_START, 8'h00, 1'b0, BUS_STUCK_LOW);
    run_cmd(ACT_READ, 8'h00, 1'b1, BUS_STUCK_LOW);
    run_cmd(ACT_BAD_6, 8'h00, 1'b0, BUS_STUCK_LOW);
    set_config(16'd1, 16'hFFFF);
    run_cmd(ACT_READ, 8'h00, 1'b0, BUS_IDLE_HIGH);
    run_cmd(ACT_WRITE, 8'($urandom), 1'b0, BUS_NOISY);
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (ticks_due.size() == 0) begin
        report_mismatch("beat with nothing due", 1, 0);
      end else begin
        want = ticks_due.pop_front();
        if (out_scl_release !== want.scl_release)
          report_mismatch("scl_release", int'(out_scl_release), int'(want.scl_release));
        if (out_sda_release !== want.sda_release)
          report_mismatch("sda_release", int'(out_sda_release), int'(want.sda_release));
        if (out_busy_res !== want.busy_res)
          report_mismatch("busy_res", int'(out_busy_res), int'(want.busy_res));
        if (out_done_res !== want.done_res)
          report_mismatch("done_res", int'(out_done_res), int'(want.done_res));
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", int'(out_read_data), int'(want.read_data));
        if (out_ack_received !== want.ack_received)
          report_mismatch("ack_received", int'(out_ack_received), int'(want.ack_received));
        if (want.done_res) cmds_done++;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed_commands();
    test_random_traffic(16'd1, 16'd2, 0, 0);
    test_random_traffic(16'd2, 16'd5, 69, 0);
    test_random_traffic(16'd1, 16'd1, 0, 69);
    test_random_traffic(16'd0, 16'd0, 6, 6);
    test_backpressure();
    test_config_extremes();
    settle();
    $display("%0d ticks checked, %0d commands completed, %0d register writes", ticks_sent,
             cmds_done, cfg_writes);
    $display("covered reset config, every command and bus fault, random mixes, hold, extremes");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
